FILE: src/mmc_pkg.sv
// mmc_pkg: shared types, constants and the arctangent table for the MET muon correction.
// No dependencies.
package mmc_pkg;

	localparam int CordicStagesDefault = 16;
	localparam int AngW = 34;      // internal angle, 2^31 = pi, room for wrap
	localparam int TrigW = 33;     // Q30 unit vector with CORDIC gain
	localparam int VecW = 48;      // Q16 x/y components
	localparam logic signed [TrigW-1:0] KinvQ30 = 33'sh026DD3B6A;
	localparam logic signed [AngW-1:0] HalfPi = 34'sh040000000;
	localparam logic signed [AngW-1:0] Pi = 34'sh080000000;

	typedef struct packed {
		logic [19:0] met_in;
		logic signed [15:0] met_angle_in;
		logic [19:0] muon_momentum;
		logic signed [15:0] muon_angle;
		logic [14:0] track_polar;
		logic signed [15:0] track_azimuth;
		logic [19:0] em_deposit;
		logic [19:0] hadron_deposit;
		logic [19:0] outer_deposit;
	} mmc_in_t;

	typedef struct packed {
		logic [19:0] met_out;
		logic signed [15:0] met_angle_out;
	} mmc_out_t;

	function automatic logic signed [AngW-1:0] atan_entry(input int i);
		logic [31:0] tab [32];
		tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
			32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
			32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
			32'h00000000, 32'h00000000};
		return AngW'(signed'({2'b00, tab[i]}));
	endfunction

endpackage

FILE: src/mmc_rot.sv
// mmc_rot: pipelined rotation-mode CORDIC giving unit cos/sin in Q30 of four angles at once.
// Depends on mmc_pkg.
module mmc_rot #(
	parameter int CORDIC_STAGES = mmc_pkg::CordicStagesDefault,
	parameter int SIDE_W = 8
) (
	input  logic clk,
	input  logic en,
	input  logic signed [mmc_pkg::AngW-1:0] ang [4],
	input  logic [SIDE_W-1:0] side,
	output logic signed [mmc_pkg::TrigW-1:0] unit_cos [4],
	output logic signed [mmc_pkg::TrigW-1:0] unit_sin [4],
	output logic [SIDE_W-1:0] side_dly
);
	import mmc_pkg::*;

	logic signed [TrigW-1:0] x_s [CORDIC_STAGES+1][4];
	logic signed [TrigW-1:0] y_s [CORDIC_STAGES+1][4];
	logic signed [AngW-1:0] z_s [CORDIC_STAGES+1][4];
	logic [SIDE_W-1:0] side_s [CORDIC_STAGES+1];

	// pre-rotate by a quarter turn into the convergence range
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (ang[k] > HalfPi) begin
				x_s[0][k] = '0; y_s[0][k] = KinvQ30; z_s[0][k] = ang[k] - HalfPi;
			end else if (ang[k] < -HalfPi) begin
				x_s[0][k] = '0; y_s[0][k] = -KinvQ30; z_s[0][k] = ang[k] + HalfPi;
			end else begin
				x_s[0][k] = KinvQ30; y_s[0][k] = '0; z_s[0][k] = ang[k];
			end
		end
		side_s[0] = side;
	end

	// one micro-rotation per register stage
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 4; k++) begin
					if (z_s[i][k] >= 0) begin
						x_s[i+1][k] <= x_s[i][k] - (y_s[i][k] >>> i);
						y_s[i+1][k] <= y_s[i][k] + (x_s[i][k] >>> i);
						z_s[i+1][k] <= z_s[i][k] - atan_entry(i);
					end else begin
						x_s[i+1][k] <= x_s[i][k] + (y_s[i][k] >>> i);
						y_s[i+1][k] <= y_s[i][k] - (x_s[i][k] >>> i);
						z_s[i+1][k] <= z_s[i][k] + atan_entry(i);
					end
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign unit_cos = x_s[CORDIC_STAGES];
	assign unit_sin = y_s[CORDIC_STAGES];
	assign side_dly = side_s[CORDIC_STAGES];

endmodule

FILE: src/met_muon_correction.sv
// met_muon_correction: MET correction for one muon, fully pipelined.
// Throughput: one word per cycle; the whole pipe advances when the output
// register is free or being taken, so a stall holds every stage.
// Reset clears the valid bits only; data registers are not reset.
// Depends on mmc_pkg and mmc_rot.
module met_muon_correction #(
	parameter int CORDIC_STAGES = mmc_pkg::CordicStagesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mmc_pkg::mmc_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output mmc_pkg::mmc_out_t out_data
);
	import mmc_pkg::*;

	// valid bits ahead of the output register
	localparam int Lat = 2 * CORDIC_STAGES + 5;
	localparam int SideW = 20 + 20 + 22;

	logic en;
	logic [Lat-1:0] vld_q;
	logic out_valid_q;
	mmc_out_t out_q;

	// advance when the output register can take a word
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], in_valid};
			out_valid_q <= vld_q[Lat-1];
		end
	end

	// stage 0: angles to internal format, sum the deposits
	logic signed [AngW-1:0] ang [4];
	logic [SideW-1:0] side_in, side_out;
	always_comb begin
		ang[0] = AngW'(in_data.met_angle_in) <<< 16;
		ang[1] = AngW'(in_data.muon_angle) <<< 16;
		ang[2] = AngW'(signed'({1'b0, in_data.track_polar})) <<< 16;
		ang[3] = AngW'(in_data.track_azimuth) <<< 16;
		side_in = {in_data.met_in, in_data.muon_momentum,
			22'(in_data.em_deposit) + 22'(in_data.hadron_deposit)
			+ 22'(in_data.outer_deposit)};
	end

	logic signed [TrigW-1:0] cs [4];
	logic signed [TrigW-1:0] sn [4];

	mmc_rot #(.CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(SideW)) u_rot (
		.clk, .en, .ang, .side(side_in),
		.unit_cos(cs), .unit_sin(sn), .side_dly(side_out)
	);

	// stage A: energy times unit vectors
	logic signed [VecW-1:0] mx_a, my_a, ux_a, uy_a, p_a;
	logic signed [TrigW-7:0] cph_a, sph_a;
	always_ff @(posedge clk) begin
		if (en) begin
			mx_a <= VecW'((64'(signed'({1'b0, side_out[61:42]})) * 64'(cs[0])) >>> 14);
			my_a <= VecW'((64'(signed'({1'b0, side_out[61:42]})) * 64'(sn[0])) >>> 14);
			ux_a <= VecW'((64'(signed'({1'b0, side_out[41:22]})) * 64'(cs[1])) >>> 14);
			uy_a <= VecW'((64'(signed'({1'b0, side_out[41:22]})) * 64'(sn[1])) >>> 14);
			p_a <= VecW'((64'(signed'({1'b0, side_out[21:0]})) * 64'(sn[2])) >>> 14);
			cph_a <= (TrigW-6)'(cs[3] >>> 6);
			sph_a <= (TrigW-6)'(sn[3] >>> 6);
		end
	end

	// stage B: project deposits by the track azimuth, subtract the muon from the MET
	logic signed [VecW-1:0] dx_b, dy_b, mx_b, my_b;
	always_ff @(posedge clk) begin
		if (en) begin
			dx_b <= VecW'((64'(p_a) * 64'(cph_a)) >>> 24);
			dy_b <= VecW'((64'(p_a) * 64'(sph_a)) >>> 24);
			mx_b <= mx_a - ux_a;
			my_b <= my_a - uy_a;
		end
	end

	// stage C: final x/y sums
	logic signed [VecW-1:0] x_c, y_c;
	always_ff @(posedge clk) begin
		if (en) begin
			x_c <= mx_b + dx_b;
			y_c <= my_b + dy_b;
		end
	end

	// stage D: fold into the right half plane
	logic signed [VecW+1:0] vx [CORDIC_STAGES+1];
	logic signed [VecW+1:0] vy [CORDIC_STAGES+1];
	logic signed [AngW-1:0] vz [CORDIC_STAGES+1];
	logic vzero [CORDIC_STAGES+1];
	always_ff @(posedge clk) begin
		if (en) begin
			vzero[0] <= (x_c == 0) && (y_c == 0);
			if (x_c < 0) begin
				vx[0] <= -(VecW+2)'(x_c); vy[0] <= -(VecW+2)'(y_c); vz[0] <= Pi;
			end else begin
				vx[0] <= (VecW+2)'(x_c); vy[0] <= (VecW+2)'(y_c); vz[0] <= '0;
			end
		end
	end

	// vectoring CORDIC, one step per stage
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				vzero[i+1] <= vzero[i];
				if (vy[i] >= 0) begin
					vx[i+1] <= vx[i] + (vy[i] >>> i);
					vy[i+1] <= vy[i] - (vx[i] >>> i);
					vz[i+1] <= vz[i] + atan_entry(i);
				end else begin
					vx[i+1] <= vx[i] - (vy[i] >>> i);
					vy[i+1] <= vy[i] + (vx[i] >>> i);
					vz[i+1] <= vz[i] - atan_entry(i);
				end
			end
		end
	end

	// stage E: gain correction multiply
	logic signed [79:0] mag_e;
	logic [15:0] ang_e;
	logic zero_e;
	logic signed [AngW-1:0] zr;
	assign zr = vz[CORDIC_STAGES] + AngW'(32768);
	always_ff @(posedge clk) begin
		if (en) begin
			mag_e <= (80'(vx[CORDIC_STAGES]) * 80'(KinvQ30 >>> 8)) >>> 22;
			ang_e <= zr[31:16];
			zero_e <= vzero[CORDIC_STAGES];
		end
	end

	// stage F: round, saturate, hold in the output register
	logic signed [79:0] mag_r;
	assign mag_r = (mag_e + 80'sd32768) >>> 16;
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_e) begin
				out_q <= '0;
			end else begin
				out_q.met_angle_out <= ang_e;
				if (mag_r > 80'sd1048575) out_q.met_out <= 20'hFFFFF;
				else if (mag_r < 0) out_q.met_out <= '0;
				else out_q.met_out <= mag_r[19:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
